/* hdl/cltc_pkg.sv */
// ----------------------------------------------------------------------------
// cltc_pkg
// Types and constants shared by the literal token classifier modules.
// ----------------------------------------------------------------------------
package cltc_pkg;

    localparam int MODE_W = 5;
    localparam int SFX_W  = 5;
    localparam int ERR_W  = 4;
    localparam int KIND_W = 3;
    localparam int CH_W   = 8;

    // scanner modes
    localparam logic [MODE_W-1:0] M_START         = 5'd0;
    localparam logic [MODE_W-1:0] M_PFX1          = 5'd1;
    localparam logic [MODE_W-1:0] M_PFX_U8        = 5'd2;
    localparam logic [MODE_W-1:0] M_ZERO          = 5'd3;
    localparam logic [MODE_W-1:0] M_DEC_INT       = 5'd4;
    localparam logic [MODE_W-1:0] M_DEC_FRAC      = 5'd5;
    localparam logic [MODE_W-1:0] M_DEC_EXP_SIGN  = 5'd6;
    localparam logic [MODE_W-1:0] M_DEC_EXP_FIRST = 5'd7;
    localparam logic [MODE_W-1:0] M_DEC_EXP_DIG   = 5'd8;
    localparam logic [MODE_W-1:0] M_HEX_INT       = 5'd9;
    localparam logic [MODE_W-1:0] M_HEX_FRAC      = 5'd10;
    localparam logic [MODE_W-1:0] M_HEX_END       = 5'd11;
    localparam logic [MODE_W-1:0] M_HEX_EXP_SIGN  = 5'd12;
    localparam logic [MODE_W-1:0] M_HEX_EXP_FIRST = 5'd13;
    localparam logic [MODE_W-1:0] M_HEX_EXP_DIG   = 5'd14;
    localparam logic [MODE_W-1:0] M_SUFFIX        = 5'd15;
    localparam logic [MODE_W-1:0] M_CHAR_BODY     = 5'd16;
    localparam logic [MODE_W-1:0] M_STR_BODY      = 5'd17;
    localparam logic [MODE_W-1:0] M_CHAR_DONE     = 5'd18;
    localparam logic [MODE_W-1:0] M_STR_DONE      = 5'd19;
    localparam logic [MODE_W-1:0] M_ERR           = 5'd20;

    // suffix flag bits
    localparam int SF_U    = 0;
    localparam int SF_L    = 1;
    localparam int SF_PEND = 2;
    localparam int SF_SIZE = 3;
    localparam int SF_IMAG = 4;

    // prefix letter codes
    localparam logic [1:0] PFX_BIG_L   = 2'd0;
    localparam logic [1:0] PFX_SMALL_U = 2'd1;
    localparam logic [1:0] PFX_BIG_U   = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_STR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLOAT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERR   = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE        = 4'd0;
    localparam logic [ERR_W-1:0] ERR_UNTERM_CHAR = 4'd1;
    localparam logic [ERR_W-1:0] ERR_UNTERM_STR  = 4'd2;
    localparam logic [ERR_W-1:0] ERR_FLOAT_SFX   = 4'd3;
    localparam logic [ERR_W-1:0] ERR_INT_SFX     = 4'd4;
    localparam logic [ERR_W-1:0] ERR_NO_HEX_DIG  = 4'd5;
    localparam logic [ERR_W-1:0] ERR_HEX_NO_EXP  = 4'd6;
    localparam logic [ERR_W-1:0] ERR_NO_P_DIG    = 4'd7;
    localparam logic [ERR_W-1:0] ERR_NO_E_DIG    = 4'd8;
    localparam logic [ERR_W-1:0] ERR_MALFORMED   = 4'd9;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [1:0]        pfx;
        logic              is_float;
        logic              any_dig;
        logic              esc;
        logic [SFX_W-1:0]  sfx;
        logic              pend_upper;
        logic [ERR_W-1:0]  err;
    } t_scan_state;

    localparam t_scan_state ST_RESET = '{
        mode: M_START, pfx: PFX_BIG_L, is_float: 1'b0, any_dig: 1'b0, esc: 1'b0,
        sfx: '0, pend_upper: 1'b0, err: ERR_NONE
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  code;
    } t_result;

endpackage

/* hdl/cltc_in_if.sv */
// ----------------------------------------------------------------------------
// cltc_in_if
// Token byte channel: one byte of literal text per word, with a last flag.
// ----------------------------------------------------------------------------
interface cltc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

/* hdl/cltc_out_if.sv */
// ----------------------------------------------------------------------------
// cltc_out_if
// Classification channel: token kind and error code, one word per token.
// ----------------------------------------------------------------------------
interface cltc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [3:0] error_code;

    modport source (output valid, output kind, output error_code, input ready);
    modport sink   (input valid, input kind, input error_code, output ready);
endinterface

/* hdl/cltc_next.sv */
// ----------------------------------------------------------------------------
// cltc_next
// Scanner next-state logic: steps the mode machine over one byte and, on the
// last byte, over the end marker, then classifies the token.
// ----------------------------------------------------------------------------
module cltc_next (
    input  cltc_pkg::t_scan_state i_st,
    input  logic [7:0]            i_ch,
    input  logic                  i_last,
    output cltc_pkg::t_scan_state o_st,
    output cltc_pkg::t_result     o_res
);
    import cltc_pkg::*;

    // worst fall-through chain is three modes deep
    localparam int STEP_MAX = 3;

    // bit 8 set marks end of token
    localparam logic [8:0] END_MARK = 9'h100;
    localparam logic [8:0] C_SQ     = 9'h027;
    localparam logic [8:0] C_DQ     = 9'h022;
    localparam logic [8:0] C_BSL    = 9'h05C;
    localparam logic [8:0] C_NL     = 9'h00A;
    localparam logic [8:0] C_DOT    = 9'h02E;
    localparam logic [8:0] C_PLUS   = 9'h02B;
    localparam logic [8:0] C_MINUS  = 9'h02D;
    localparam logic [8:0] C_0      = 9'h030;
    localparam logic [8:0] C_8      = 9'h038;
    localparam logic [8:0] C_9      = 9'h039;
    localparam logic [8:0] C_UA     = 9'h041;
    localparam logic [8:0] C_UE     = 9'h045;
    localparam logic [8:0] C_UF     = 9'h046;
    localparam logic [8:0] C_UI     = 9'h049;
    localparam logic [8:0] C_UJ     = 9'h04A;
    localparam logic [8:0] C_UL     = 9'h04C;
    localparam logic [8:0] C_UP     = 9'h050;
    localparam logic [8:0] C_UU     = 9'h055;
    localparam logic [8:0] C_UX     = 9'h058;
    localparam logic [8:0] C_UZ     = 9'h05A;
    localparam logic [8:0] C_USC    = 9'h05F;
    localparam logic [8:0] C_LA     = 9'h061;
    localparam logic [8:0] C_LE     = 9'h065;
    localparam logic [8:0] C_LF     = 9'h066;
    localparam logic [8:0] C_LI     = 9'h069;
    localparam logic [8:0] C_LJ     = 9'h06A;
    localparam logic [8:0] C_LL     = 9'h06C;
    localparam logic [8:0] C_LP     = 9'h070;
    localparam logic [8:0] C_LU     = 9'h075;
    localparam logic [8:0] C_LX     = 9'h078;
    localparam logic [8:0] C_LZ     = 9'h07A;

    typedef struct packed {
        t_scan_state st;
        logic        again;
    } t_step;

    function automatic logic is_dig(logic [8:0] c);
        return (c >= C_0) && (c <= C_9);
    endfunction

    function automatic logic is_hex(logic [8:0] c);
        return is_dig(c) || ((c >= C_LA) && (c <= C_LF)) || ((c >= C_UA) && (c <= C_UF));
    endfunction

    function automatic logic is_ident(logic [8:0] c);
        return is_dig(c) || ((c >= C_LA) && (c <= C_LZ)) || ((c >= C_UA) && (c <= C_UZ))
            || (c == C_USC);
    endfunction

    function automatic t_scan_state fail(t_scan_state s, logic [ERR_W-1:0] code);
        t_scan_state r;
        r      = s;
        r.err  = code;
        r.mode = M_ERR;
        return r;
    endfunction

    // one suffix character; failure goes straight to the error mode
    function automatic t_scan_state sfx_char(t_scan_state s, logic [8:0] c);
        t_scan_state r;
        logic        pend_hit;
        r        = s;
        pend_hit = s.sfx[SF_PEND] && (s.pend_upper ? (c == C_UL) : (c == C_LL));
        if (s.is_float) begin
            if ((c == C_LF) || (c == C_UF) || (c == C_LL) || (c == C_UL)) begin
                if (s.sfx[SF_SIZE]) r = fail(s, ERR_FLOAT_SFX);
                else r.sfx[SF_SIZE] = 1'b1;
            end else if ((c == C_LI) || (c == C_UI) || (c == C_LJ) || (c == C_UJ)) begin
                if (s.sfx[SF_IMAG]) r = fail(s, ERR_FLOAT_SFX);
                else r.sfx[SF_IMAG] = 1'b1;
            end else begin
                r = fail(s, ERR_FLOAT_SFX);
            end
        end else if (pend_hit) begin
            r.sfx[SF_PEND] = 1'b0;
        end else begin
            r.sfx[SF_PEND] = 1'b0;
            if (((c == C_LU) || (c == C_UU)) && !s.sfx[SF_U]) begin
                r.sfx[SF_U] = 1'b1;
            end else if (((c == C_LL) || (c == C_UL)) && !s.sfx[SF_L]) begin
                r.sfx[SF_L]    = 1'b1;
                r.sfx[SF_PEND] = 1'b1;
                r.pend_upper   = (c == C_UL);
            end else begin
                r = fail(r, ERR_INT_SFX);
            end
        end
        return r;
    endfunction

    function automatic t_step scan_step(t_scan_state s, logic [8:0] c);
        t_step r;
        logic  hx;
        logic  sign_ok;
        logic  chr;
        r.st    = s;
        r.again = 1'b0;
        hx      = (s.mode == M_HEX_EXP_SIGN) || (s.mode == M_HEX_EXP_FIRST);
        sign_ok = (s.mode == M_DEC_EXP_SIGN) || (s.mode == M_HEX_EXP_SIGN);
        chr     = (s.mode == M_CHAR_BODY);
        case (s.mode)
            M_START: begin
                if (c == C_SQ) r.st.mode = M_CHAR_BODY;
                else if (c == C_DQ) r.st.mode = M_STR_BODY;
                else if ((c == C_UL) || (c == C_LU) || (c == C_UU)) begin
                    r.st.pfx  = (c == C_UL) ? PFX_BIG_L : ((c == C_LU) ? PFX_SMALL_U : PFX_BIG_U);
                    r.st.mode = M_PFX1;
                end else if (c == C_0) r.st.mode = M_ZERO;
                else begin
                    r.st.mode = M_DEC_INT;
                    r.again   = 1'b1;
                end
            end
            M_PFX1: begin
                if (c == C_SQ) r.st.mode = M_CHAR_BODY;
                else if (c == C_DQ) r.st.mode = M_STR_BODY;
                else if ((s.pfx == PFX_SMALL_U) && (c == C_8)) r.st.mode = M_PFX_U8;
                else begin
                    if (s.pfx == PFX_BIG_L) begin
                        r.st.sfx        = '0;
                        r.st.sfx[SF_L]    = 1'b1;
                        r.st.sfx[SF_PEND] = 1'b1;
                        r.st.pend_upper   = 1'b1;
                    end else begin
                        r.st.sfx       = '0;
                        r.st.sfx[SF_U] = 1'b1;
                    end
                    r.st.mode = M_SUFFIX;
                    r.again   = 1'b1;
                end
            end
            M_PFX_U8: begin
                if (c == C_DQ) r.st.mode = M_STR_BODY;
                else r.st = fail(s, ERR_INT_SFX);
            end
            M_ZERO: begin
                if ((c == C_LX) || (c == C_UX)) r.st.mode = M_HEX_INT;
                else begin
                    r.st.mode = M_DEC_INT;
                    r.again   = 1'b1;
                end
            end
            M_DEC_INT, M_DEC_FRAC: begin
                if (!is_dig(c)) begin
                    if ((c == C_DOT) && (s.mode == M_DEC_INT)) begin
                        r.st.is_float = 1'b1;
                        r.st.mode     = M_DEC_FRAC;
                    end else if ((c == C_LE) || (c == C_UE)) begin
                        r.st.is_float = 1'b1;
                        r.st.mode     = M_DEC_EXP_SIGN;
                    end else begin
                        r.st.mode = M_SUFFIX;
                        r.again   = 1'b1;
                    end
                end
            end
            M_HEX_INT, M_HEX_FRAC: begin
                if (is_hex(c)) r.st.any_dig = 1'b1;
                else if ((c == C_DOT) && (s.mode == M_HEX_INT)) begin
                    r.st.is_float = 1'b1;
                    r.st.mode     = M_HEX_FRAC;
                end else begin
                    r.st.mode = M_HEX_END;
                    r.again   = 1'b1;
                end
            end
            M_HEX_END: begin
                if (!s.any_dig) r.st = fail(s, ERR_NO_HEX_DIG);
                else if ((c == C_LP) || (c == C_UP)) begin
                    r.st.is_float = 1'b1;
                    r.st.mode     = M_HEX_EXP_SIGN;
                end else if (s.is_float) r.st = fail(s, ERR_HEX_NO_EXP);
                else begin
                    r.st.mode = M_SUFFIX;
                    r.again   = 1'b1;
                end
            end
            M_DEC_EXP_SIGN, M_HEX_EXP_SIGN, M_DEC_EXP_FIRST, M_HEX_EXP_FIRST: begin
                if (is_dig(c)) r.st.mode = hx ? M_HEX_EXP_DIG : M_DEC_EXP_DIG;
                else if (sign_ok && ((c == C_PLUS) || (c == C_MINUS)))
                    r.st.mode = hx ? M_HEX_EXP_FIRST : M_DEC_EXP_FIRST;
                else r.st = fail(s, hx ? ERR_NO_P_DIG : ERR_NO_E_DIG);
            end
            M_DEC_EXP_DIG, M_HEX_EXP_DIG: begin
                if (!is_dig(c)) begin
                    r.st.mode = M_SUFFIX;
                    r.again   = 1'b1;
                end
            end
            M_SUFFIX: begin
                if (c != END_MARK) begin
                    if (!is_ident(c)) r.st = fail(s, ERR_MALFORMED);
                    else r.st = sfx_char(s, c);
                end
            end
            M_CHAR_BODY, M_STR_BODY: begin
                if (c == END_MARK) r.st = fail(s, chr ? ERR_UNTERM_CHAR : ERR_UNTERM_STR);
                else if (s.esc) r.st.esc = 1'b0;
                else if (c == (chr ? C_SQ : C_DQ)) r.st.mode = chr ? M_CHAR_DONE : M_STR_DONE;
                else if (c == C_NL) r.st = fail(s, chr ? ERR_UNTERM_CHAR : ERR_UNTERM_STR);
                else if (c == C_BSL) r.st.esc = 1'b1;
            end
            M_CHAR_DONE, M_STR_DONE: begin
                if (c != END_MARK) r.st = fail(s, ERR_MALFORMED);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_scan_state feed(t_scan_state s, logic [8:0] c);
        t_scan_state st;
        t_step       t;
        logic        go;
        st = s;
        go = 1'b1;
        for (int k = 0; k < STEP_MAX; k++) begin
            if (go) begin
                t  = scan_step(st, c);
                st = t.st;
                go = t.again;
            end
        end
        return st;
    endfunction

    t_scan_state st_byte;
    t_scan_state st_end;

    always_comb begin
        st_byte = feed(i_st, {1'b0, i_ch});
        st_end  = feed(st_byte, END_MARK);
        o_res.kind = KIND_ERR;
        o_res.code = ERR_NONE;
        case (st_end.mode)
            M_SUFFIX:    o_res.kind = st_end.is_float ? KIND_FLOAT : KIND_INT;
            M_CHAR_DONE: o_res.kind = KIND_CHAR;
            M_STR_DONE:  o_res.kind = KIND_STR;
            M_ERR:       o_res.code = st_end.err;
            default:     o_res.code = ERR_MALFORMED;
        endcase
        o_st = i_last ? ST_RESET : st_byte;
    end

endmodule

/* hdl/c_literal_token_classifier_unit.sv */
// ----------------------------------------------------------------------------
// c_literal_token_classifier_unit
// Classifies a C literal token streamed one byte per word; reports kind and
// error code on the token's last byte.
//
//   channel  dir  words                 payload
//   i_tok    in   one per token byte    ch[7:0], last
//   o_res    out  one per token         kind[2:0], error_code[3:0]
//
// One byte word is taken every cycle while no last byte waits on a held result;
// the scanner state register closes a loop through the next-state logic.
// On the result path the last byte lands in the input register, then the verdict
// in the result register, which also raises the result word's valid.
// i_rst_n is synchronous; it returns the scanner to token start and drops
// both valid flags. A held result stalls only a last byte behind it.
// ----------------------------------------------------------------------------
module c_literal_token_classifier_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cltc_in_if.sink           i_tok,
    cltc_out_if.source        o_res
);
    import cltc_pkg::*;

    logic              r_in_valid;
    logic [CH_W-1:0]   r_ch;
    logic              r_last;
    t_scan_state       r_st;
    t_scan_state       n_st;
    t_result           n_res;
    logic              r_out_valid;
    t_result           r_res;
    logic              out_free;
    logic              s1_go;

    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_go       = r_in_valid && (!r_last || out_free);
    assign i_tok.ready = !r_in_valid || s1_go;

    cltc_next u_next (
        .i_st   (r_st),
        .i_ch   (r_ch),
        .i_last (r_last),
        .o_st   (n_st),
        .o_res  (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_st        <= ST_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_tok.ready) begin
                r_in_valid <= i_tok.valid;
            end
            if (s1_go) begin
                r_st <= n_st;
            end
            if (s1_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid && i_tok.ready) begin
            r_ch   <= i_tok.ch;
            r_last <= i_tok.last;
        end
        if (s1_go && r_last) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_res.kind;
    assign o_res.error_code = r_res.code;

`ifndef SYNTHESIS
    a_err_code_iff_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.kind == KIND_ERR) == (r_res.code != ERR_NONE)))
        else $error("error code does not match kind");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_last) |=> (r_st == ST_RESET))
        else $error("scanner not back at token start after last byte");

    a_word_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s1_go) |=> (r_in_valid && $stable(r_ch) && $stable(r_last)))
        else $error("stalled byte word lost");

    a_err_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.mode == M_ERR) |-> (r_st.err != ERR_NONE))
        else $error("error mode without error code");
`endif

endmodule
